// ----- rtl/core/rmd_pkg.sv -----
package rmd_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [31:0] KL1 = 32'h5A827999;
	localparam logic [31:0] KL2 = 32'h6ED9EBA1;
	localparam logic [31:0] KR0 = 32'h50A28BE6;
	localparam logic [31:0] KR2 = 32'h5C4DD124;
	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	// One queued word for the back end: the word itself and its role.
	typedef struct packed {
		logic [31:0] word;
		logic        fin;    // closes the message: pad and emit digest
		logic [2:0]  nbytes; // valid bytes of a final word (0..4)
	} qent_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_COMB,
		ST_PAD,
		ST_OUT
	} bstate_t;

	function automatic logic [3:0] msg_idx(input logic [1:0] r, input logic [3:0] i);
		logic [3:0] v;
		v = i;
		unique case (r)
			2'd0: v = i;
			2'd1: begin
				unique case (i)
					4'd0: v = 4'd7;   4'd1: v = 4'd4;   4'd2: v = 4'd13;  4'd3: v = 4'd1;
					4'd4: v = 4'd10;  4'd5: v = 4'd6;   4'd6: v = 4'd15;  4'd7: v = 4'd3;
					4'd8: v = 4'd12;  4'd9: v = 4'd0;   4'd10: v = 4'd9;  4'd11: v = 4'd5;
					4'd12: v = 4'd14; 4'd13: v = 4'd2;  4'd14: v = 4'd11; default: v = 4'd8;
				endcase
			end
			default: begin
				unique case (i)
					4'd0: v = 4'd3;   4'd1: v = 4'd10;  4'd2: v = 4'd2;   4'd3: v = 4'd4;
					4'd4: v = 4'd9;   4'd5: v = 4'd15;  4'd6: v = 4'd8;   4'd7: v = 4'd1;
					4'd8: v = 4'd14;  4'd9: v = 4'd7;   4'd10: v = 4'd0;  4'd11: v = 4'd6;
					4'd12: v = 4'd11; 4'd13: v = 4'd13; 4'd14: v = 4'd5;  default: v = 4'd12;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [1:0] r, input logic [3:0] i);
		logic [4:0] v;
		v = 5'd0;
		unique case (r)
			2'd0: begin
				unique case (i)
					4'd0: v = 5'd11;  4'd1: v = 5'd14;  4'd2: v = 5'd15;  4'd3: v = 5'd12;
					4'd4: v = 5'd5;   4'd5: v = 5'd8;   4'd6: v = 5'd7;   4'd7: v = 5'd9;
					4'd8: v = 5'd11;  4'd9: v = 5'd13;  4'd10: v = 5'd14; 4'd11: v = 5'd15;
					4'd12: v = 5'd6;  4'd13: v = 5'd7;  4'd14: v = 5'd9;  default: v = 5'd8;
				endcase
			end
			2'd1: begin
				unique case (i)
					4'd0: v = 5'd7;   4'd1: v = 5'd6;   4'd2: v = 5'd8;   4'd3: v = 5'd13;
					4'd4: v = 5'd11;  4'd5: v = 5'd9;   4'd6: v = 5'd7;   4'd7: v = 5'd15;
					4'd8: v = 5'd7;   4'd9: v = 5'd12;  4'd10: v = 5'd15; 4'd11: v = 5'd9;
					4'd12: v = 5'd7;  4'd13: v = 5'd11; 4'd14: v = 5'd13; default: v = 5'd12;
				endcase
			end
			default: begin
				unique case (i)
					4'd0: v = 5'd11;  4'd1: v = 5'd13;  4'd2: v = 5'd14;  4'd3: v = 5'd7;
					4'd4: v = 5'd14;  4'd5: v = 5'd9;   4'd6: v = 5'd13;  4'd7: v = 5'd15;
					4'd8: v = 5'd6;   4'd9: v = 5'd8;   4'd10: v = 5'd13; 4'd11: v = 5'd6;
					4'd12: v = 5'd12; 4'd13: v = 5'd5;  4'd14: v = 5'd7;  default: v = 5'd5;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rnd_f(input logic [1:0] r, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] z);
		logic [31:0] v;
		unique case (r)
			2'd0: v = ((y ^ z) & x) ^ z;
			2'd1: v = (x & y) | ((x | y) & z);
			default: v = x ^ y ^ z;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] d;
		d = {v, v} << s;
		return d[63:32];
	endfunction

endpackage

// ----- rtl/core/rmd_front.sv -----
module rmd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [31:0]   data_word,
	input  logic [2:0]    byte_count,
	input  logic          is_last,
	output logic          q_valid,
	input  logic          q_ready,
	output rmd_pkg::qent_t q_data
);
	rmd_pkg::qent_t mem_q [rmd_pkg::QDEPTH];
	logic [rmd_pkg::QAW:0] wp_q, rp_q;
	logic [2:0] nb;
	logic [31:0] mask;
	logic push, pop;

	assign in_ready = (wp_q - rp_q) != 3'(rmd_pkg::QDEPTH);
	assign q_valid  = wp_q != rp_q;
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_data   = mem_q[rp_q[rmd_pkg::QAW-1:0]];

	// Final words are trimmed to their valid bytes here; the back end pads.
	always_comb begin
		nb = is_last ? ((byte_count > 3'd4) ? 3'd4 : byte_count) : 3'd4;
		unique case (nb)
			3'd0: mask = 32'h0;
			3'd1: mask = 32'h000000ff;
			3'd2: mask = 32'h0000ffff;
			3'd3: mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q[rmd_pkg::QAW-1:0]] <= '{word: data_word & mask, fin: is_last, nbytes: nb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
		end
	end
endmodule

// ----- rtl/core/rmd_back.sv -----
module rmd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  rmd_pkg::qent_t q_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    digest_word,
	output logic           digest_end,
	output logic           busy
);
	rmd_pkg::bstate_t st_q, st_d;
	logic [31:0] buf_q [16];
	logic [31:0] cv_q [4];
	logic [31:0] la_q, lb_q, lc_q, ld_q, ra_q, rb_q, rc_q, rd_q;
	logic [63:0] len_q;
	logic [3:0]  wpos_q;
	logic [1:0]  rnd_q;
	logic [3:0]  stp_q;
	logic        fin_q;   // finishing the message: pad words follow
	logic        padb_q;  // the 0x80 word is still owed (four-byte final word)
	logic        lenok_q; // the 0x80 byte is placed and slots 14/15 are free for the length
	logic        lenw_q;  // length words have been written
	logic [1:0]  oidx_q;

	logic        wr_en;
	logic [31:0] wr_word;
	logic [31:0] kl, kr, tl, tr, ml, mr;
	logic [4:0]  sl, sr;
	logic [63:0] bits;

	assign bits = {len_q[60:0], 3'b000};

	always_comb begin
		unique case (rnd_q)
			2'd0: begin kl = 32'h0; kr = rmd_pkg::KR0; end
			2'd1: begin kl = rmd_pkg::KL1; kr = 32'h0; end
			default: begin kl = rmd_pkg::KL2; kr = rmd_pkg::KR2; end
		endcase
		ml = buf_q[rmd_pkg::msg_idx(rnd_q, stp_q)];
		mr = ml;
		sl = rmd_pkg::rot_amt(rnd_q, stp_q);
		sr = sl;
		tl = rmd_pkg::rotl(la_q + rmd_pkg::rnd_f(rnd_q, lb_q, lc_q, ld_q) + ml + kl, sl);
		tr = rmd_pkg::rotl(ra_q + rmd_pkg::rnd_f(rnd_q, rb_q, rc_q, rd_q) + mr + kr, sr);
	end

	always_comb begin
		st_d      = st_q;
		q_ready   = 1'b0;
		wr_en     = 1'b0;
		wr_word   = 32'h0;
		out_valid = 1'b0;
		unique case (st_q)
			rmd_pkg::ST_LOAD: begin
				q_ready = 1'b1;
				if (q_valid) begin
					wr_en = 1'b1;
					if (q_data.fin && q_data.nbytes != 3'd4) begin
						wr_word = q_data.word | (rmd_pkg::PAD_BYTE << {q_data.nbytes[1:0], 3'b000});
					end else begin
						wr_word = q_data.word;
					end
					if (wpos_q == 4'd15) st_d = rmd_pkg::ST_ROUND;
					else if (q_data.fin) st_d = rmd_pkg::ST_PAD;
				end
			end
			rmd_pkg::ST_PAD: begin
				wr_en = 1'b1;
				// Length goes in 14/15 only when the 0x80 byte landed at slot 13 or
				// below; otherwise this block is zero filled and the next one holds it.
				if (padb_q) wr_word = rmd_pkg::PAD_BYTE;
				else if (lenok_q && wpos_q == 4'd14) wr_word = bits[31:0];
				else if (lenok_q && wpos_q == 4'd15) wr_word = bits[63:32];
				else wr_word = 32'h0;
				if (wpos_q == 4'd15) st_d = rmd_pkg::ST_ROUND;
			end
			rmd_pkg::ST_ROUND: begin
				if (rnd_q == 2'd2 && stp_q == 4'd15) st_d = rmd_pkg::ST_COMB;
			end
			rmd_pkg::ST_COMB: begin
				st_d = fin_q ? (!lenw_q ? rmd_pkg::ST_PAD : rmd_pkg::ST_OUT)
					: rmd_pkg::ST_LOAD;
			end
			rmd_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready && oidx_q == 2'd3) st_d = rmd_pkg::ST_LOAD;
			end
			default: st_d = rmd_pkg::ST_LOAD;
		endcase
	end

	assign digest_word = cv_q[oidx_q];
	assign digest_end  = oidx_q == 2'd3;
	assign busy        = st_q != rmd_pkg::ST_LOAD;

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[wpos_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= rmd_pkg::ST_LOAD;
			cv_q    <= '{rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3};
			len_q   <= '0;
			wpos_q  <= '0;
			rnd_q   <= '0;
			stp_q   <= '0;
			fin_q   <= 1'b0;
			padb_q  <= 1'b0;
			lenok_q <= 1'b0;
			lenw_q  <= 1'b0;
			oidx_q  <= '0;
			la_q <= '0; lb_q <= '0; lc_q <= '0; ld_q <= '0;
			ra_q <= '0; rb_q <= '0; rc_q <= '0; rd_q <= '0;
		end else begin
			st_q <= st_d;
			if (wr_en) wpos_q <= wpos_q + 1'b1;
			if (st_q == rmd_pkg::ST_LOAD && q_valid) begin
				len_q <= len_q + 64'(q_data.nbytes);
				if (q_data.fin) begin
					fin_q   <= 1'b1;
					padb_q  <= q_data.nbytes == 3'd4;
					lenok_q <= (q_data.nbytes != 3'd4) && (wpos_q <= 4'd13);
					lenw_q  <= 1'b0;
				end
			end
			if (st_q == rmd_pkg::ST_PAD) begin
				padb_q <= 1'b0;
				if (padb_q) lenok_q <= wpos_q <= 4'd13;
				if (!padb_q && lenok_q && wpos_q == 4'd15) lenw_q <= 1'b1;
			end
			if (st_d == rmd_pkg::ST_ROUND && st_q != rmd_pkg::ST_ROUND) begin
				la_q <= cv_q[0]; lb_q <= cv_q[1]; lc_q <= cv_q[2]; ld_q <= cv_q[3];
				ra_q <= cv_q[0]; rb_q <= cv_q[1]; rc_q <= cv_q[2]; rd_q <= cv_q[3];
				rnd_q <= '0;
				stp_q <= '0;
			end
			if (st_q == rmd_pkg::ST_ROUND) begin
				la_q <= ld_q; ld_q <= lc_q; lc_q <= lb_q; lb_q <= tl;
				ra_q <= rd_q; rd_q <= rc_q; rc_q <= rb_q; rb_q <= tr;
				stp_q <= stp_q + 1'b1;
				if (stp_q == 4'd15) rnd_q <= rnd_q + 1'b1;
			end
			if (st_q == rmd_pkg::ST_COMB) begin
				cv_q[0] <= cv_q[1] + lc_q + rd_q;
				cv_q[1] <= cv_q[2] + ld_q + ra_q;
				cv_q[2] <= cv_q[3] + la_q + rb_q;
				cv_q[3] <= cv_q[0] + lb_q + rc_q;
				lenok_q <= 1'b1;
			end
			if (st_q == rmd_pkg::ST_OUT && out_ready) begin
				oidx_q <= oidx_q + 1'b1;
				if (oidx_q == 2'd3) begin
					cv_q   <= '{rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3};
					len_q  <= '0;
					wpos_q <= '0;
					fin_q  <= 1'b0;
				end
			end
		end
	end
endmodule

// ----- rtl/core/ripemd_original_hash_core.sv -----
// Original RIPEMD 128-bit hash core.
// Input channel (in_valid/in_ready): one beat carries a 32-bit little-endian
// message word, a byte count and is_last. byte_count matters only on the
// final beat (values above four count as four); earlier beats are four bytes.
// Output channel (out_valid/out_ready): four beats per message, digest words
// A, B, C, D, with digest_end set on the fourth.
// A four-entry queue separates the accepting front end from the compression
// back end, so input beats keep landing while a block is compressed.
// Each 16-word block is loaded, then run through the rounds (both lines
// step together through the shared round logic), then combined; the back
// end takes no queued words while it compresses. The final beat adds padding fill
// to slot 15, one or two compressions, then the four digest beats.
// If the receiver stalls, the back end holds on the current digest word and
// the queue fills, after which in_ready drops.
// Reset returns the chaining value to the initial words, clears the length
// and empties the queue; no clearing pass is needed.
module ripemd_original_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic        digest_end
);
	logic           q_valid, q_ready, busy;
	rmd_pkg::qent_t q_data;

	rmd_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_word, .byte_count, .is_last,
		.q_valid, .q_ready, .q_data
	);

	rmd_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .digest_word, .digest_end, .busy
	);

	// Digest beats only come out of a busy back end.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> busy)
		else $error("digest beat while back end idle");
	// A stalled digest beat holds its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word))
		else $error("digest word changed under stall");
	// The back end never takes from the queue while it emits digest beats.
	assert property (@(posedge clk) disable iff (!arst_n) q_ready |-> !out_valid)
		else $error("queue drained during output");
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the original RIPEMD 128-bit hash core.
// Messages are streamed as word beats; a scoreboard object hashes each
// accepted beat on its own copy of the state and queues the digest words
// that the final beat of a message produces. Output beats are compared
// against the oldest queued digest word, field by field.
module tb_top;

	// Digest word the core should emit, paired with its end marker.
	typedef struct {
		logic [31:0] word;
		logic        fin;
	} digest_exp_t;

	// Software copy of the hash state plus the queue of pending digest words.
	class digest_board;
		logic [31:0] chain [4];
		logic [31:0] blk [16];
		logic [63:0] nbytes;
		int unsigned wpos;
		digest_exp_t pending [$];
		int unsigned errors;
		int unsigned digests;

		function new();
			errors = 0;
			digests = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = 32'h67452301;
			chain[1] = 32'hefcdab89;
			chain[2] = 32'h98badcfe;
			chain[3] = 32'h10325476;
			nbytes = '0;
			wpos = 0;
		endfunction

		function logic [31:0] mix(int unsigned r, logic [31:0] x, logic [31:0] y,
				logic [31:0] z);
			if (r == 0) return ((y ^ z) & x) ^ z;
			if (r == 1) return (x & y) | ((x | y) & z);
			return x ^ y ^ z;
		endfunction

		// Runs one line of 48 steps on v using the given round constants.
		function void run_line(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
				ref logic [31:0] v [4]);
			int unsigned ord [3][16] = '{
				'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
				'{7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 14, 2, 11, 8},
				'{3, 10, 2, 4, 9, 15, 8, 1, 14, 7, 0, 6, 11, 13, 5, 12}};
			int unsigned rot [3][16] = '{
				'{11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8},
				'{7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 7, 11, 13, 12},
				'{11, 13, 14, 7, 14, 9, 13, 15, 6, 8, 13, 6, 12, 5, 7, 5}};
			logic [31:0] a, b, c, d, t, kc;
			logic [63:0] dbl;
			a = v[0]; b = v[1]; c = v[2]; d = v[3];
			for (int r = 0; r < 3; r++) begin
				kc = (r == 0) ? k0 : (r == 1) ? k1 : k2;
				for (int i = 0; i < 16; i++) begin
					t = a + mix(r, b, c, d) + blk[ord[r][i]] + kc;
					dbl = {t, t} << rot[r][i];
					t = dbl[63:32];
					a = d; d = c; c = b; b = t;
				end
			end
			v[0] = a; v[1] = b; v[2] = c; v[3] = d;
		endfunction

		function void compress();
			logic [31:0] l [4];
			logic [31:0] r [4];
			logic [31:0] t;
			l = chain;
			r = chain;
			run_line(32'h0, rmd_pkg::KL1, rmd_pkg::KL2, l);
			run_line(rmd_pkg::KR0, 32'h0, rmd_pkg::KR2, r);
			t = chain[1] + l[2] + r[3];
			chain[1] = chain[2] + l[3] + r[0];
			chain[2] = chain[3] + l[0] + r[1];
			chain[3] = chain[0] + l[1] + r[2];
			chain[0] = t;
		endfunction

		function void put_word(logic [31:0] w);
			blk[wpos] = w;
			wpos = (wpos + 1) % 16;
			if (wpos == 0) compress();
		endfunction

		// Notes an accepted input beat and queues any digest it completes.
		function void note_beat(logic [31:0] data, logic [2:0] cnt, logic last);
			int unsigned nb;
			logic [31:0] mask;
			logic [63:0] bits;
			digest_exp_t e;
			if (!last) begin
				nbytes += 4;
				put_word(data);
				return;
			end
			nb = (cnt > 4) ? 4 : cnt;
			nbytes += nb;
			if (nb == 4) begin
				put_word(data);
				put_word(rmd_pkg::PAD_BYTE);
			end else begin
				mask = (nb == 0) ? 32'h0 : (32'hFFFFFFFF >> (32 - 8 * nb));
				put_word((data & mask) | (rmd_pkg::PAD_BYTE << (8 * nb)));
			end
			if (wpos > 14) while (wpos != 0) put_word(32'h0);
			while (wpos < 14) put_word(32'h0);
			bits = nbytes << 3;
			put_word(bits[31:0]);
			put_word(bits[63:32]);
			for (int k = 0; k < 4; k++) begin
				e.word = chain[k];
				e.fin = (k == 3);
				pending.push_back(e);
			end
			digests++;
			restart();
		endfunction

		// Compares one output beat against the oldest pending digest word.
		function void check_beat(logic [31:0] word, logic fin);
			digest_exp_t e;
			if (pending.size() == 0) begin
				$error("unexpected digest beat %h", word);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (word !== e.word) begin
				$error("digest_word expected %h actual %h", e.word, word);
				errors++;
			end
			if (fin !== e.fin) begin
				$error("digest_end expected %b actual %b", e.fin, fin);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic        digest_end;

	digest_board board;
	int unsigned beats_sent;
	int unsigned idle_cycles;
	bit          calm;       // set for the final part of the run: no idling
	bit          timed_out;

	ripemd_original_hash_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_word(data_word), .byte_count(byte_count), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .digest_end(digest_end)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Output beats are checked at the edge that accepts them. The receiver
	// stalls in random bursts until the calm part of the run begins.
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		hold = 0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_beat(digest_word, digest_end);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 13) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: counts edges at which neither channel accepts a beat.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// Presents one beat and holds it until accepted. The random gap comes
	// first, so valid never drops between two beats sent back to back.
	task automatic send_beat(logic [31:0] data, logic [2:0] cnt, logic last);
		int unsigned gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_word <= data;
		byte_count <= cnt;
		is_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_beat(data, cnt, last);
		beats_sent++;
	endtask

	// Streams a message of nwords full words followed by a final beat.
	task automatic send_message(int unsigned nwords, logic [2:0] cnt);
		for (int i = 0; i < nwords; i++) send_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_beat($urandom, cnt, 1'b1);
	endtask

	task automatic drain_digests();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned len;
		board = new();
		beats_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		is_last = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty message, every final byte count including the
		// saturated ones, extreme data words, and lengths that put the final
		// word at slots 13, 14 and 15 so that padding spills into a second block.
		send_beat(32'hFFFFFFFF, 3'd0, 1'b1);
		send_beat(32'hFFFFFFFF, 3'd1, 1'b1);
		send_beat(32'h00000000, 3'd2, 1'b1);
		send_beat(32'hFFFFFFFF, 3'd3, 1'b1);
		send_beat(32'hFFFFFFFF, 3'd4, 1'b1);
		send_beat(32'hA5A5A5A5, 3'd5, 1'b1);
		send_beat(32'h5A5A5A5A, 3'd7, 1'b1);
		send_message(13, 3'd4);
		drain_digests();
		send_message(14, 3'd2);
		send_message(15, 3'd6);

		// The sender holds off here until every digest word has arrived.
		drain_digests();

		// Random messages, mostly short, a few spanning several blocks.
		while (beats_sent < 315) begin
			if (beats_sent > 260) calm = 1'b1;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
				: $urandom_range(0, 17);
			send_message(len, 3'($urandom_range(0, 7)));
		end
		in_valid <= 1'b0;
		calm = 1'b1;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Hashed %0d messages from %0d input beats, including empty, ",
			board.digests, beats_sent);
		$display("saturated byte counts and two-block padding, with stalls both sides.");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
